### src/ppmd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ppmd_pkg
// Register indexes and fixed constants of the position PID motor drive.
// ----------------------------------------------------------------------------
package ppmd_pkg;

    // Configuration register indexes
    localparam logic [2:0] CFG_SETPOINT = 3'd0;
    localparam logic [2:0] CFG_GAIN_P   = 3'd1;
    localparam logic [2:0] CFG_GAIN_I   = 3'd2;
    localparam logic [2:0] CFG_GAIN_D   = 3'd3;
    localparam logic [2:0] CFG_TSTEP    = 3'd4;
    localparam logic [2:0] CFG_WINDUP   = 3'd5;
    localparam logic [2:0] CFG_PERIOD   = 3'd6;

    localparam logic signed [16:0] WRAP_SPAN = 17'sd1320;
    localparam logic signed [16:0] DEAD_BAND = 17'sd2;
    localparam logic [15:0]        FULL_SCALE = 16'hFFFF;
    localparam logic [6:0]         DUTY_MIN   = 7'd10;
    localparam logic [6:0]         DUTY_MAX   = 7'd95;
    localparam logic [63:0]        TERM_LIMIT = 64'h1000_0000_0000_0000;
    // ceil(2^30 / 100): exact quotient by 100 for any 23-bit dividend.
    localparam logic [23:0]        RECIP_100  = 24'd10737419;

endpackage

### src/pid_position_motor_drive_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pid_position_motor_drive_core
// Encoder wrap, deadband and fixed-point PID with anti-windup, bit-serial.
// ----------------------------------------------------------------------------
// An item is taken only while the sequencer is idle, so no new item enters
// before the last has left it. A driving item walks DIV, MUL, SUM, UPD, PW,
// OUT; a deadband item jumps to OUT. OUT waits for a free output register.
// The work is done by the 33-step restoring divider followed by the 32-step
// shift-add multipliers. Reset is synchronous and active low; it loads the
// register defaults and clears the integrator and the stored error.
// ----------------------------------------------------------------------------
module pid_position_motor_drive_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // configuration write port
    input  logic        i_cfg_wr_en,
    input  logic [2:0]  i_cfg_addr,
    input  logic [31:0] i_cfg_wdata,
    // input item channel
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [15:0] i_raw_position,
    // result item channel
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [15:0] o_wrapped_position,
    output logic        o_drive_enable,
    output logic        o_direction,
    output logic [6:0]  o_duty_percent,
    output logic [15:0] o_pulse_width
);

    // Sequencer states. An item walks IDLE -> DIV -> MUL -> SUM -> UPD -> PW
    // -> OUT; a deadband item jumps from IDLE straight to OUT.
    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_DIV  = 3'd1;
    localparam logic [2:0] S_MUL  = 3'd2;
    localparam logic [2:0] S_SUM  = 3'd3;
    localparam logic [2:0] S_UPD  = 3'd4;
    localparam logic [2:0] S_PW   = 3'd5;
    localparam logic [2:0] S_OUT  = 3'd6;

    // Configuration registers.
    logic signed [15:0] r_setpoint;
    logic signed [31:0] r_gain_p, r_gain_i, r_gain_d;
    logic [15:0]        r_time_step, r_period;
    logic               r_windup;

    // Controller state.
    logic signed [47:0] r_integ;
    logic signed [17:0] r_prev_err;

    // Per-item working registers.
    logic [2:0]         r_state;
    logic [5:0]         r_cnt;
    logic [15:0]        r_pos;
    logic               r_dead;
    logic signed [17:0] r_e;
    logic [16:0]        r_e_mag;
    logic               r_diff_neg;
    logic [32:0]        r_num;      // numerator, shifted out as quotient bits shift in
    logic [15:0]        r_rem;
    logic [48:0]        r_pp_p;     // {partial sum, multiplier bits} per product
    logic [79:0]        r_pp_i;
    logic [64:0]        r_pp_d;
    logic signed [63:0] r_u;
    logic               r_dir;
    logic [6:0]         r_duty;
    logic [22:0]        r_prod;

    // Output register, which frees the sequencer while a result waits.
    logic               r_out_valid;
    logic [15:0]        r_o_pos;
    logic               r_o_en, r_o_dir;
    logic [6:0]         r_o_duty;
    logic [15:0]        r_o_pw;

    // ---------------- input stage: wrap, deadband, error ----------------
    logic signed [16:0] w_raw, w_wrap;
    logic signed [17:0] w_e, w_diff;
    logic [17:0]        w_e_abs, w_diff_abs;
    logic               w_dead, w_accept;
    logic [15:0]        w_dt;
    logic [47:0]        w_integ_mag;

    assign w_raw = {i_raw_position[15], i_raw_position};

    always_comb begin
        w_wrap = w_raw;
        if (w_raw > ppmd_pkg::WRAP_SPAN) begin
            w_wrap = w_raw - ppmd_pkg::WRAP_SPAN;
        end else if (w_raw < -ppmd_pkg::WRAP_SPAN) begin
            w_wrap = w_raw + ppmd_pkg::WRAP_SPAN;
        end
    end

    assign w_dead     = (w_wrap >= -ppmd_pkg::DEAD_BAND) && (w_wrap <= ppmd_pkg::DEAD_BAND);
    assign w_e        = {{2{r_setpoint[15]}}, r_setpoint} - {w_wrap[16], w_wrap};
    assign w_diff     = w_e - r_prev_err;
    assign w_e_abs    = w_e[17] ? -w_e : w_e;
    assign w_diff_abs = w_diff[17] ? -w_diff : w_diff;
    // A zero time step behaves as the smallest step.
    assign w_dt       = (r_time_step == 16'd0) ? 16'd1 : r_time_step;
    assign w_integ_mag = r_integ[47] ? 48'(-r_integ) : 48'(r_integ);

    // The sequencer takes an item whenever it is idle; a finished result
    // sits in the output register meanwhile.
    assign o_in_ready = (r_state == S_IDLE);
    assign w_accept   = i_in_valid && o_in_ready;

    // ---------------- restoring divider, one quotient bit per cycle ------
    logic [16:0] w_trial;
    logic        w_qbit;
    logic [15:0] w_rem_next;
    logic [32:0] w_num_next;

    assign w_trial    = {r_rem, r_num[32]};
    assign w_qbit     = (w_trial >= {1'b0, w_dt});
    assign w_rem_next = w_qbit ? 16'(w_trial - {1'b0, w_dt}) : w_trial[15:0];
    assign w_num_next = {r_num[31:0], w_qbit};

    // ---------------- shift-add multipliers, one gain bit per cycle ------
    logic [17:0] w_sum_p;
    logic [48:0] w_sum_i;
    logic [33:0] w_sum_d;

    assign w_sum_p = {1'b0, r_pp_p[48:32]} + (r_pp_p[0] ? {1'b0, r_e_mag} : 18'd0);
    assign w_sum_i = {1'b0, r_pp_i[79:32]} + (r_pp_i[0] ? {1'b0, w_integ_mag} : 49'd0);
    assign w_sum_d = {1'b0, r_pp_d[64:32]} + (r_pp_d[0] ? {1'b0, r_num} : 34'd0);

    // ---------------- term saturation and sum ----------------
    logic [63:0]        w_ti_raw, w_ti, w_td, w_tp;
    logic signed [63:0] w_sp, w_si, w_sd;

    assign w_ti_raw = r_pp_i[79:16];
    assign w_ti     = (w_ti_raw > ppmd_pkg::TERM_LIMIT) ? ppmd_pkg::TERM_LIMIT : w_ti_raw;
    assign w_td     = (r_pp_d > {1'b0, ppmd_pkg::TERM_LIMIT}) ? ppmd_pkg::TERM_LIMIT
                                                               : r_pp_d[63:0];
    assign w_tp     = {15'd0, r_pp_p};
    assign w_sp     = (r_gain_p[31] ^ r_e[17])   ? -$signed(w_tp) : $signed(w_tp);
    assign w_si     = (r_gain_i[31] ^ r_integ[47]) ? -$signed(w_ti) : $signed(w_ti);
    assign w_sd     = (r_gain_d[31] ^ r_diff_neg) ? -$signed(w_td) : $signed(w_td);

    // ---------------- saturation test, duty and integrator ----------------
    logic [63:0]        w_um;
    logic               w_sat, w_hold;
    logic [22:0]        w_n100;
    logic [6:0]         w_q0, w_q;
    logic [16:0]        w_r;
    logic [6:0]         w_duty;
    logic signed [16:0] w_dt_s;
    logic signed [34:0] w_dte;
    logic signed [48:0] w_ni;
    logic signed [47:0] w_ni_sat;

    assign w_um  = r_u[63] ? 64'(-r_u) : 64'(r_u);
    assign w_sat = (w_um >= {32'd0, ppmd_pkg::FULL_SCALE, 16'd0});
    // Integer part times 100, divided by 65535 via the 2^16 reciprocal and
    // one correction step.
    assign w_n100 = 23'(w_um[31:16]) * 23'd100;
    assign w_q0   = w_n100[22:16];
    assign w_r    = {1'b0, w_n100[15:0]} + {10'd0, w_q0};
    assign w_q    = (w_r >= {1'b0, ppmd_pkg::FULL_SCALE}) ? w_q0 + 7'd1 : w_q0;

    always_comb begin
        if (w_um[63:16] >= {32'd0, ppmd_pkg::FULL_SCALE}) begin
            w_duty = ppmd_pkg::DUTY_MAX;
        end else if (w_q < ppmd_pkg::DUTY_MIN) begin
            w_duty = ppmd_pkg::DUTY_MIN;
        end else if (w_q > ppmd_pkg::DUTY_MAX) begin
            w_duty = ppmd_pkg::DUTY_MAX;
        end else begin
            w_duty = w_q;
        end
    end

    // Anti-windup: hold when enabled, saturated and error and integrator share a sign.
    assign w_hold = w_sat && (r_e[17] == r_integ[47]) && r_windup;
    assign w_dt_s = {1'b0, w_dt};
    assign w_dte  = 35'(w_dt_s) * 35'(r_e);
    assign w_ni   = {r_integ[47], r_integ} + {{14{w_dte[34]}}, w_dte};

    always_comb begin
        if (w_ni > 49'sh0_7FFF_FFFF_FFFF) begin
            w_ni_sat = 48'sh7FFF_FFFF_FFFF;
        end else if (w_ni < -49'sh0_8000_0000_0000) begin
            w_ni_sat = 48'sh8000_0000_0000;
        end else begin
            w_ni_sat = w_ni[47:0];
        end
    end

    // Pulse width = duty * period / 100 through the exact reciprocal.
    logic [46:0] w_pw_full;
    assign w_pw_full = 47'(r_prod) * 47'(ppmd_pkg::RECIP_100);

    logic w_out_free;
    assign w_out_free = !r_out_valid || i_out_ready;

    // ---------------- configuration ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_setpoint  <= '0;
            r_gain_p    <= 32'sd65536;
            r_gain_i    <= '0;
            r_gain_d    <= '0;
            r_time_step <= 16'd655;
            r_windup    <= 1'b1;
            r_period    <= 16'd1000;
        end else if (i_cfg_wr_en) begin
            unique case (i_cfg_addr)
                ppmd_pkg::CFG_SETPOINT: r_setpoint  <= i_cfg_wdata[15:0];
                ppmd_pkg::CFG_GAIN_P:   r_gain_p    <= i_cfg_wdata;
                ppmd_pkg::CFG_GAIN_I:   r_gain_i    <= i_cfg_wdata;
                ppmd_pkg::CFG_GAIN_D:   r_gain_d    <= i_cfg_wdata;
                ppmd_pkg::CFG_TSTEP:    r_time_step <= i_cfg_wdata[15:0];
                ppmd_pkg::CFG_WINDUP:   r_windup    <= i_cfg_wdata[0];
                ppmd_pkg::CFG_PERIOD:   r_period    <= i_cfg_wdata[15:0];
                default: ;
            endcase
        end
    end

    // ---------------- sequencer and datapath ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_cnt      <= '0;
            r_integ    <= '0;
            r_prev_err <= '0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        r_pos      <= w_wrap[15:0];
                        r_dead     <= w_dead;
                        r_e        <= w_e;
                        r_e_mag    <= w_e_abs[16:0];
                        r_diff_neg <= w_diff[17];
                        r_num      <= {w_diff_abs[16:0], 16'd0};
                        r_rem      <= '0;
                        r_cnt      <= '0;
                        r_pp_p     <= {17'd0, (r_gain_p[31] ? 32'(-r_gain_p) : 32'(r_gain_p))};
                        r_pp_i     <= {48'd0, (r_gain_i[31] ? 32'(-r_gain_i) : 32'(r_gain_i))};
                        r_state    <= w_dead ? S_OUT : S_DIV;
                    end
                end
                S_DIV: begin
                    r_num <= w_num_next;
                    r_rem <= w_rem_next;
                    if (r_cnt == 6'd32) begin
                        r_cnt   <= '0;
                        r_pp_d  <= {33'd0, (r_gain_d[31] ? 32'(-r_gain_d) : 32'(r_gain_d))};
                        r_state <= S_MUL;
                    end else begin
                        r_cnt <= r_cnt + 6'd1;
                    end
                end
                S_MUL: begin
                    r_pp_p <= {w_sum_p, r_pp_p[31:1]};
                    r_pp_i <= {w_sum_i, r_pp_i[31:1]};
                    r_pp_d <= {w_sum_d, r_pp_d[31:1]};
                    if (r_cnt == 6'd31) begin
                        r_state <= S_SUM;
                    end else begin
                        r_cnt <= r_cnt + 6'd1;
                    end
                end
                S_SUM: begin
                    r_u     <= w_sp + w_si + w_sd;
                    r_state <= S_UPD;
                end
                S_UPD: begin
                    if (!w_hold) begin
                        r_integ <= w_ni_sat;
                    end
                    r_prev_err <= r_e;
                    r_dir      <= r_u[63];
                    r_duty     <= w_duty;
                    r_state    <= S_PW;
                end
                S_PW: begin
                    r_prod  <= 23'(r_duty) * 23'(r_period);
                    r_state <= S_OUT;
                end
                S_OUT: begin
                    if (w_out_free) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // ---------------- output register ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (r_state == S_OUT && w_out_free) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_OUT && w_out_free) begin
            r_o_pos <= r_pos;
            if (r_dead) begin
                r_o_en   <= 1'b0;
                r_o_dir  <= 1'b0;
                r_o_duty <= '0;
                r_o_pw   <= '0;
            end else begin
                r_o_en   <= 1'b1;
                r_o_dir  <= r_dir;
                r_o_duty <= r_duty;
                r_o_pw   <= w_pw_full[45:30];
            end
        end
    end

    assign o_out_valid        = r_out_valid;
    assign o_wrapped_position = r_o_pos;
    assign o_drive_enable     = r_o_en;
    assign o_direction        = r_o_dir;
    assign o_duty_percent     = r_o_duty;
    assign o_pulse_width      = r_o_pw;

endmodule

### src/ppmd_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ppmd_checker
// Port-level checks of the position PID motor drive, bound to the top level.
// ----------------------------------------------------------------------------
module ppmd_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_out_valid,
    input logic        i_out_ready,
    input logic        o_drive_enable,
    input logic        o_direction,
    input logic [6:0]  o_duty_percent,
    input logic [15:0] o_pulse_width
);

    // A waiting result item stays until taken.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_pulse_width))
        else $error("result item dropped while stalled");

    // A deadband result carries no drive.
    a_dead: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_drive_enable |->
            o_duty_percent == 7'd0 && o_pulse_width == 16'd0 && !o_direction)
        else $error("deadband result carries drive");

    // A driving result has its duty inside the clamp range.
    a_duty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_drive_enable |->
            o_duty_percent >= ppmd_pkg::DUTY_MIN && o_duty_percent <= ppmd_pkg::DUTY_MAX)
        else $error("duty outside clamp range");

    // No result appears in the cycle after reset.
    a_rst: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid after reset");

endmodule

bind pid_position_motor_drive_core ppmd_checker u_ppmd_checker (.*);
